@@ sv/sbpd_pkg.sv @@
`timescale 1ns / 1ps

package sbpd_pkg;

	localparam int FFT_SIZE_DEF = 1024;
	localparam int BIN_W = 9;
	localparam int LVL_W = 16;
	localparam int COMP_W = 32;
	localparam int STORE_DEPTH = 512;
	localparam int FE_STAGES = 24;
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	localparam logic [15:0] COEFF_RST = 16'd58982;
	localparam logic [19:0] DB_SLOPE_Q24 = 20'd561161;
	// log2 of full-scale squared magnitude, q16
	localparam logic [21:0] LOG_FS = 22'd4063232;
	localparam logic [5:0] SAT_EXP = 6'd62;

	localparam logic REG_DECAY_COEFF = 1'b0;

	typedef struct packed {
		logic [BIN_W-1:0] bin;
		logic             last;
		logic [LVL_W-1:0] fresh;
	} item_t;

	// one squaring step of the log2 mantissa: {fraction bit, new mantissa}
	function automatic logic [32:0] sq_step(input logic [31:0] y);
		logic [63:0] p;
		logic [32:0] t;
		p = {32'd0, y} * {32'd0, y};
		t = p[63:31];
		sq_step = t[32] ? {1'b1, t[32:1]} : {1'b0, t[31:0]};
	endfunction

	function automatic logic [2:0] top_bit8(input logic [7:0] v);
		logic [2:0] r;
		r = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (v[i]) r = 3'(i);
		end
		return r;
	endfunction

	function automatic logic [2:0] top_byte(input logic [63:0] v);
		logic [2:0] r;
		r = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (v[8*i +: 8] != 8'd0) r = 3'(i);
		end
		return r;
	endfunction

endpackage

@@ sv/sbpd_front.sv @@
`timescale 1ns / 1ps

module sbpd_front #(
	parameter int FFT_SIZE = sbpd_pkg::FFT_SIZE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             hold,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [sbpd_pkg::BIN_W-1:0]       bin_index,
	input  logic signed [sbpd_pkg::COMP_W-1:0] real_part,
	input  logic signed [sbpd_pkg::COMP_W-1:0] imag_part,
	output logic                             fe_valid,
	output sbpd_pkg::item_t                  fe_item,
	input  logic                             fe_ready
);

	localparam int NS = sbpd_pkg::FE_STAGES;
	localparam int LAST = FFT_SIZE / 2 - 1;

	logic adv;
	logic [NS-1:0] v_s;
	logic [NS-1:0] last_s;
	logic [sbpd_pkg::BIN_W-1:0] bin_s [NS];

	logic [31:0] a_s1, b_s1;
	logic [63:0] sa_s2, sb_s2;
	logic [63:0] s_s3, s_s4, sh_s5;
	logic [2:0]  bidx_s4, kb_s5;
	logic        z_s4, z_s5, z_s6, z_s23, z_s24, sat_s23, sat_s24;
	logic [31:0] y_s6;
	logic [5:0]  k_s6;
	logic [31:0] y_s [16];
	logic [15:0] fr_s [16];
	logic [5:0]  k_s [16];
	logic [15:0] z_s;
	logic [21:0] neg_s23;
	logic [41:0] prod_s24;

	logic [2:0]  fine_c;
	logic [63:0] norm_c;
	logic [41:0] prod_r;
	logic [17:0] t_c;
	logic [32:0] st_c [16];

	assign adv = !v_s[NS-1] || fe_ready;
	assign in_ready = adv && !hold;

	assign fine_c = sbpd_pkg::top_bit8(sh_s5[63:56]);
	assign norm_c = sh_s5 << (3'd7 - fine_c);

	always_comb begin
		st_c[0] = sbpd_pkg::sq_step(y_s6);
		for (int i = 1; i < 16; i++) begin
			st_c[i] = sbpd_pkg::sq_step(y_s[i-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[NS-2:0], in_valid && in_ready};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bin_s[0] <= bin_index;
			for (int i = 1; i < NS; i++) begin
				bin_s[i] <= bin_s[i-1];
			end
			last_s <= {last_s[NS-2:0], (32'(bin_index) == 32'(LAST))};

			a_s1 <= real_part[31] ? (~real_part + 32'd1) : real_part;
			b_s1 <= imag_part[31] ? (~imag_part + 32'd1) : imag_part;
			sa_s2 <= a_s1 * a_s1;
			sb_s2 <= b_s1 * b_s1;
			s_s3 <= sa_s2 + sb_s2;
			s_s4 <= s_s3;
			z_s4 <= (s_s3 == 64'd0);
			bidx_s4 <= sbpd_pkg::top_byte(s_s3);
			sh_s5 <= s_s4 << {3'd7 - bidx_s4, 3'b000};
			kb_s5 <= bidx_s4;
			z_s5 <= z_s4;
			y_s6 <= norm_c[63:32];
			k_s6 <= {kb_s5, fine_c};
			z_s6 <= z_s5;

			y_s[0] <= st_c[0][31:0];
			fr_s[0] <= {15'd0, st_c[0][32]};
			k_s[0] <= k_s6;
			z_s[0] <= z_s6;
			for (int i = 1; i < 16; i++) begin
				y_s[i] <= st_c[i][31:0];
				fr_s[i] <= {fr_s[i-1][14:0], st_c[i][32]};
				k_s[i] <= k_s[i-1];
				z_s[i] <= z_s[i-1];
			end

			sat_s23 <= (k_s[15] >= sbpd_pkg::SAT_EXP);
			neg_s23 <= sbpd_pkg::LOG_FS - {k_s[15], fr_s[15]};
			z_s23 <= z_s[15];
			prod_s24 <= neg_s23 * sbpd_pkg::DB_SLOPE_Q24;
			sat_s24 <= sat_s23;
			z_s24 <= z_s23;
		end
	end

	assign prod_r = prod_s24 + 42'd8388608;
	assign t_c = prod_r[41:24];

	always_comb begin
		fe_item.bin = bin_s[NS-1];
		fe_item.last = last_s[NS-1];
		priority if (z_s24) begin
			fe_item.fresh = '0;
		end else if (sat_s24) begin
			fe_item.fresh = 16'hFFFF;
		end else if (t_c >= 18'd65536) begin
			fe_item.fresh = '0;
		end else if (t_c == 18'd0) begin
			fe_item.fresh = 16'hFFFF;
		end else begin
			fe_item.fresh = 16'(18'd65536 - t_c);
		end
	end

	assign fe_valid = v_s[NS-1];

endmodule

@@ sv/sbpd_fifo.sv @@
`timescale 1ns / 1ps

module sbpd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sbpd_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            q_valid,
	output sbpd_pkg::item_t q_item
);

	localparam int PW = sbpd_pkg::Q_PTR_W;

	sbpd_pkg::item_t mem_q [sbpd_pkg::Q_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;

	assign full = (cnt_q == (PW+1)'(sbpd_pkg::Q_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_item = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

endmodule

@@ sv/sbpd_back.sv @@
`timescale 1ns / 1ps

module sbpd_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [15:0]                coeff,
	input  logic                       q_valid,
	input  sbpd_pkg::item_t            q_item,
	output logic                       q_ready,
	output logic                       clr_busy,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [sbpd_pkg::BIN_W-1:0] bin_out,
	output logic [sbpd_pkg::LVL_W-1:0] level,
	output logic                       last_bin
);

	logic [15:0] mem [sbpd_pkg::STORE_DEPTH];
	logic        clr_busy_q;
	logic [sbpd_pkg::BIN_W-1:0] clr_q;

	logic            v_s1, fwd_s1, ov_q;
	sbpd_pkg::item_t it_s1;
	logic [15:0]     rd_s1, fwdv_s1;

	logic        adv2, b1_load, b1_move;
	logic [15:0] old_c, upd_c;
	logic [31:0] po_c;
	logic [32:0] pn_c;
	logic [33:0] sum_c;

	assign adv2 = !ov_q || out_ready;
	assign b1_move = v_s1 && adv2;
	assign q_ready = !clr_busy_q && (!v_s1 || adv2);
	assign b1_load = q_valid && q_ready;
	assign clr_busy = clr_busy_q;
	assign out_valid = ov_q;

	assign old_c = fwd_s1 ? fwdv_s1 : rd_s1;
	assign po_c = old_c * coeff;
	assign pn_c = it_s1.fresh * (17'd65536 - {1'b0, coeff});
	assign sum_c = {2'b00, po_c} + {1'b0, pn_c} + 34'd32768;
	assign upd_c = (it_s1.fresh > old_c) ? it_s1.fresh : sum_c[31:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_q <= '0;
			v_s1 <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == '1) clr_busy_q <= 1'b0;
			end
			if (b1_load) v_s1 <= 1'b1;
			else if (b1_move) v_s1 <= 1'b0;
			if (b1_move) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_q] <= '0;
		end else if (b1_move) begin
			mem[it_s1.bin] <= upd_c;
		end
		if (b1_load) begin
			rd_s1 <= mem[q_item.bin];
			it_s1 <= q_item;
			fwd_s1 <= b1_move && (it_s1.bin == q_item.bin);
			fwdv_s1 <= upd_c;
		end
		if (b1_move) begin
			bin_out <= it_s1.bin;
			level <= upd_c;
			last_bin <= it_s1.last;
		end
	end

endmodule

@@ sv/spectrum_bin_peak_decay.sv @@
`timescale 1ns / 1ps

// spectrum bin peak-hold meter with exponential decay
// input channel (in_valid/in_ready): one fft bin per transfer, bin_index with
// real_part and imag_part; output channel (out_valid/out_ready): bin_out, the
// updated q0.16 display level and last_bin for the final bin of a frame
// throughput: one bin per cycle sustained while out_ready stays high, set by the
// fully pipelined log2 unit (16 squaring stages, one multiplier each) and the
// one-read one-write level memory read-modify-write with forwarding between
// back-to-back equal bins
// decay_coeff sits at apb byte address 0, reset value 58982
// after reset the level memory (512 entries) is cleared and in_ready stays low
// meanwhile; apb writes are taken at any time
// when the receiver stalls, the output register holds, the back end and the
// 4-entry queue fill, then the front pipeline stops and in_ready drops
module spectrum_bin_peak_decay #(
	parameter int FFT_SIZE = sbpd_pkg::FFT_SIZE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [2:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [sbpd_pkg::BIN_W-1:0]         bin_index,
	input  logic signed [sbpd_pkg::COMP_W-1:0] real_part,
	input  logic signed [sbpd_pkg::COMP_W-1:0] imag_part,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [sbpd_pkg::BIN_W-1:0]         bin_out,
	output logic [sbpd_pkg::LVL_W-1:0]         level,
	output logic                               last_bin
);

	logic [15:0]     decay_q;
	logic            clr_busy, fe_valid, fe_full, q_valid, q_ready;
	sbpd_pkg::item_t fe_item, q_item;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == sbpd_pkg::REG_DECAY_COEFF) ? {16'd0, decay_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= sbpd_pkg::COEFF_RST;
		end else if (psel && penable && pwrite && paddr[2] == sbpd_pkg::REG_DECAY_COEFF) begin
			decay_q <= pwdata[15:0];
		end
	end

	sbpd_front #(.FFT_SIZE(FFT_SIZE)) u_front (
		.clk(clk), .arst_n(arst_n), .hold(clr_busy),
		.in_valid(in_valid), .in_ready(in_ready),
		.bin_index(bin_index), .real_part(real_part), .imag_part(imag_part),
		.fe_valid(fe_valid), .fe_item(fe_item), .fe_ready(!fe_full)
	);

	sbpd_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(fe_valid && !fe_full), .push_item(fe_item), .full(fe_full),
		.pop(q_valid && q_ready), .q_valid(q_valid), .q_item(q_item)
	);

	sbpd_back u_back (
		.clk(clk), .arst_n(arst_n), .coeff(decay_q),
		.q_valid(q_valid), .q_item(q_item), .q_ready(q_ready), .clr_busy(clr_busy),
		.out_valid(out_valid), .out_ready(out_ready),
		.bin_out(bin_out), .level(level), .last_bin(last_bin)
	);

endmodule

@@ sv/sbpd_checker.sv @@
`timescale 1ns / 1ps

module sbpd_checker #(
	parameter int FFT_SIZE = sbpd_pkg::FFT_SIZE_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic [2:0]                 paddr,
	input logic [31:0]                pwdata,
	input logic [31:0]                prdata,
	input logic                       pready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [sbpd_pkg::BIN_W-1:0] bin_out,
	input logic [sbpd_pkg::LVL_W-1:0] level,
	input logic                       last_bin
);

	localparam int LAST = FFT_SIZE / 2 - 1;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bin_out) && $stable(level)
			&& $stable(last_bin))
		else $error("output transfer dropped or changed while stalled");

	a_last_bin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_bin |-> 32'(bin_out) == 32'(LAST))
		else $error("last_bin flagged on wrong bin");

	a_coeff_rb: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr[2] == sbpd_pkg::REG_DECAY_COEFF)
			##1 (paddr[2] == sbpd_pkg::REG_DECAY_COEFF)
			|-> prdata == {16'd0, $past(pwdata[15:0])})
		else $error("decay_coeff readback mismatch");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind spectrum_bin_peak_decay sbpd_checker #(.FFT_SIZE(FFT_SIZE)) u_sbpd_checker (
	.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
	.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
	.out_valid(out_valid), .out_ready(out_ready), .bin_out(bin_out),
	.level(level), .last_bin(last_bin)
);

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

	localparam int HALF_BINS = sbpd_pkg::FFT_SIZE_DEF / 2;
	localparam longint CYCLE_LIMIT = 400000;
	localparam logic [2:0] ADDR_DECAY_COEFF = {sbpd_pkg::REG_DECAY_COEFF, 2'b00};
	localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

	typedef struct {
		logic [sbpd_pkg::BIN_W-1:0]         bin;
		logic signed [sbpd_pkg::COMP_W-1:0] re;
		logic signed [sbpd_pkg::COMP_W-1:0] im;
	} bin_sample_t;

	typedef struct {
		logic [sbpd_pkg::BIN_W-1:0] bin;
		logic [sbpd_pkg::LVL_W-1:0] lvl;
		logic                       last;
	} meter_level_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic in_valid, in_ready;
	logic [sbpd_pkg::BIN_W-1:0] bin_index;
	logic signed [sbpd_pkg::COMP_W-1:0] real_part, imag_part;
	logic out_valid, out_ready;
	logic [sbpd_pkg::BIN_W-1:0] bin_out;
	logic [sbpd_pkg::LVL_W-1:0] level;
	logic last_bin;

	bin_sample_t pending_bins[$];
	meter_level_t expected_levels[$];
	logic [sbpd_pkg::LVL_W-1:0] display_levels[sbpd_pkg::STORE_DEPTH];
	logic [15:0] smoothing_coeff;
	int send_idle_pct, recv_stall_pct;
	bit send_hold;
	int mismatch_count;
	longint cycle_count;

	spectrum_bin_peak_decay DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.bin_index(bin_index), .real_part(real_part), .imag_part(imag_part),
		.out_valid(out_valid), .out_ready(out_ready),
		.bin_out(bin_out), .level(level), .last_bin(last_bin)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] comp_magnitude(
			input logic signed [sbpd_pkg::COMP_W-1:0] v);
		logic [63:0] u;
		u = {32'd0, v};
		if (v[sbpd_pkg::COMP_W-1]) u = 64'h1_0000_0000 - u;
		return u;
	endfunction

	function automatic logic [sbpd_pkg::LVL_W-1:0] bin_db_level(
			input logic signed [sbpd_pkg::COMP_W-1:0] re,
			input logic signed [sbpd_pkg::COMP_W-1:0] im);
		logic [63:0] a, b, pwr, mant, t;
		logic [15:0] frac;
		longint k, log_q16;
		a = comp_magnitude(re);
		b = comp_magnitude(im);
		pwr = a * a + b * b;
		if (pwr == 64'd0) return '0;
		k = 0;
		for (int i = 0; i < 64; i++) begin
			if (pwr[i]) k = i;
		end
		mant = (pwr << (63 - k)) >> 32;
		frac = '0;
		for (int i = 0; i < 16; i++) begin
			mant = (mant * mant) >> 31;
			frac = frac << 1;
			if (mant >= 64'h1_0000_0000) begin
				frac[0] = 1'b1;
				mant = mant >> 1;
			end
		end
		log_q16 = k * 65536 + frac - 2 * (sbpd_pkg::COMP_W - 1) * 65536;
		if (log_q16 >= 0) return 16'hFFFF;
		t = (64'(-log_q16) * 64'd561161 + 64'd8388608) >> 24;
		if (t >= 64'd65536) return '0;
		t = 64'd65536 - t;
		return (t > 64'd65535) ? 16'hFFFF : t[15:0];
	endfunction

	function automatic meter_level_t update_meter(input bin_sample_t s);
		meter_level_t r;
		logic [sbpd_pkg::LVL_W-1:0] fresh, prev;
		logic [63:0] mix;
		fresh = bin_db_level(s.re, s.im);
		prev = display_levels[s.bin];
		if (fresh > prev) begin
			r.lvl = fresh;
		end else begin
			mix = (64'(prev) * smoothing_coeff + 64'(fresh) * (64'd65536 - smoothing_coeff)
				+ 64'd32768) >> 16;
			r.lvl = (mix > 64'd65535) ? 16'hFFFF : mix[15:0];
		end
		display_levels[s.bin] = r.lvl;
		r.bin = s.bin;
		r.last = (s.bin == sbpd_pkg::BIN_W'(HALF_BINS - 1));
		return r;
	endfunction

	// driver: predicts on each input transfer, then offers the next bin
	always @(posedge clk) begin
		bin_sample_t s;
		if (in_valid && in_ready) begin
			s.bin = bin_index;
			s.re = real_part;
			s.im = imag_part;
			expected_levels.push_back(update_meter(s));
		end
		if (!in_valid || in_ready) begin
			if (pending_bins.size() > 0 && !send_hold &&
					$urandom_range(99) >= send_idle_pct) begin
				s = pending_bins.pop_front();
				in_valid <= 1'b1;
				bin_index <= s.bin;
				real_part <= s.re;
				imag_part <= s.im;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		meter_level_t e;
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
		if (out_valid && out_ready) begin
			if (expected_levels.size() == 0) begin
				$display("%0t: unexpected transfer bin %0d level %0d", $time, bin_out, level);
				mismatch_count++;
			end else begin
				e = expected_levels.pop_front();
				if (bin_out !== e.bin || level !== e.lvl || last_bin !== e.last) begin
					$display({"%0t: mismatch expected bin %0d level %0d last %0b,",
						" actual bin %0d level %0d last %0b"},
						$time, e.bin, e.lvl, e.last, bin_out, level, last_bin);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_DECAY_COEFF) smoothing_coeff = data[15:0];
	endtask

	task automatic add_bin(input int bin, input logic [31:0] re, input logic [31:0] im);
		bin_sample_t s;
		s.bin = sbpd_pkg::BIN_W'(bin);
		s.re = re;
		s.im = im;
		pending_bins.push_back(s);
	endtask

	task automatic drain();
		do @(negedge clk);
		while (pending_bins.size() > 0 || in_valid || expected_levels.size() > 0);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_component();
		logic [31:0] v;
		int pick;
		pick = $urandom_range(19);
		if (pick == 0) return 32'h8000_0000;
		if (pick == 1) return 32'h7FFF_FFFF;
		if (pick == 2) return 32'd0;
		v = $urandom;
		return $signed(v) >>> $urandom_range(31);
	endfunction

	task automatic add_random_bins(input int count);
		int bin;
		bin = $urandom_range(HALF_BINS - 1);
		for (int i = 0; i < count; i++) begin
			// mostly fresh bins, sometimes a repeat so stored levels decay
			if ($urandom_range(3) != 0) bin = $urandom_range(($urandom_range(7) == 0) ? 7 : 511);
			if ($urandom_range(15) == 0) bin = HALF_BINS - 1;
			add_bin(bin, rand_component(), rand_component());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		bin_index = '0;
		real_part = '0;
		imag_part = '0;
		out_ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_hold = 1'b0;
		mismatch_count = 0;
		cycle_count = 0;
		smoothing_coeff = sbpd_pkg::COEFF_RST;
		for (int i = 0; i < sbpd_pkg::STORE_DEPTH; i++) display_levels[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, zero, saturation, decay on one bin, last bin
		add_bin(0, 0, 0);
		add_bin(511, 32'h8000_0000, 32'h8000_0000);
		add_bin(511, 0, 0);
		add_bin(511, 0, 0);
		add_bin(1, 32'h7FFF_FFFF, 0);
		add_bin(2, 0, 32'h8000_0000);
		add_bin(3, 1, 0);
		add_bin(4, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_bin(5, 32'h0000_8000, 32'hFFFF_8000);
		add_bin(5, 32'h0000_0100, 0);
		add_bin(5, 32'h0000_0100, 0);
		add_bin(256, 32'h4000_0000, 32'hC000_0000);
		add_bin(170, 32'h5555_5555, 32'hAAAA_AAAA);
		add_bin(85, 32'h0001_0000, 32'h0000_0001);
		add_bin(511, 32'h0000_1000, 32'h0000_1000);
		drain();

		// no idling, reset coefficient
		send_idle_pct = 0;
		recv_stall_pct = 0;
		apb_write(ADDR_DECAY_COEFF, 32'd58982);
		add_random_bins(180);
		drain();

		// sender pauses mid-stream until every result is back
		add_random_bins(180);
		repeat (60) @(posedge clk);
		send_hold = 1'b1;
		do @(negedge clk);
		while (in_valid || expected_levels.size() > 0);
		send_hold = 1'b0;
		drain();

		// sender mostly idle, no decay weight
		apb_write(ADDR_DECAY_COEFF, 32'd0);
		send_idle_pct = 84;
		recv_stall_pct = 0;
		add_random_bins(360);
		drain();

		// receiver mostly stalled, full decay weight
		apb_write(ADDR_DECAY_COEFF, 32'd65535);
		apb_write(ADDR_UNMAPPED, 32'd1234);
		send_idle_pct = 0;
		recv_stall_pct = 84;
		add_random_bins(360);
		drain();

		// both sides idle now and then
		apb_write(ADDR_DECAY_COEFF, 32'h0001_8000);
		send_idle_pct = 17;
		recv_stall_pct = 17;
		add_random_bins(360);
		drain();

		if (mismatch_count == 0 && expected_levels.size() == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
